@@ hdl/mrhs_pkg.sv @@
package mrhs_pkg;

   localparam int REG_COUNT = 16;
   localparam int IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int CNT_W     = $clog2(REG_COUNT + 1);

   localparam logic [15:0] CRC_INIT           = 16'hFFFF;
   localparam logic [15:0] CRC_POLY           = 16'hA001;
   localparam logic [7:0]  FUNC_READ_HOLDING  = 8'h03;
   localparam logic [7:0]  SLAVE_ADDR_RESET   = 8'h01;
   localparam logic [15:0] RESET_REG0         = 16'h1234;
   localparam logic [15:0] RESET_REG1         = 16'h4321;

   localparam logic        OP_LINE_BYTE = 1'b0;
   localparam logic        OP_REG_WRITE = 1'b1;

   localparam int          CSR_AW             = 3;
   localparam logic        CSR_IDX_SLAVE_ADDR = 1'b0;

   typedef struct packed {
      logic init;
      logic start;
   } crc_ctl_type;

   function automatic logic [15:0] reg_reset_value(input int idx);
      logic [15:0] v;
      v = 16'h0000;
      if (idx == 0) begin
         v = RESET_REG0;
      end else if (idx == 1) begin
         v = RESET_REG1;
      end
      return v;
   endfunction

endpackage

@@ hdl/mrhs_crc_serial.sv @@
module mrhs_crc_serial
   import mrhs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   input  logic [7:0]  data_byte,
   output logic        busy,
   output logic [15:0] crc
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  sh_ff, sh_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        fb;

   // one bit of the byte per cycle, LSB first (reflected CRC-16)
   assign fb = crc_ff[0] ^ sh_ff[0];

   always_comb begin
      crc_in  = crc_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         crc_in = {1'b0, crc_ff[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
         sh_in  = {1'b0, sh_ff[7:1]};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
      if (ctl.init) begin
         crc_in = CRC_INIT;
      end
      if (ctl.start) begin
         sh_in   = data_byte;
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         crc_ff  <= crc_in;
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff <= sh_in;
   end

   assign busy = busy_ff;
   assign crc  = crc_ff;

endmodule

@@ hdl/mrhs_reg_table.sv @@
module mrhs_reg_table
   import mrhs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [15:0]      wr_data,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [15:0]      rd_data
);

   logic [15:0] tbl_ff [REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            tbl_ff[i] <= reg_reset_value(i);
         end
      end else if (wr_en) begin
         tbl_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = tbl_ff[rd_idx];

endmodule

@@ hdl/modbus_rtu_read_holding_slave_unit.sv @@
// Modbus RTU slave for read holding registers (function 3). Each request is
// either a received line byte or a local write of one table register. Line
// bytes are hunted for the station address in the slave_address register,
// then eight bytes make a frame whose CRC-16 is checked; a good function-3
// frame with a start address inside the table is answered, a bad one is
// dropped silently. The CRC runs through a shared bit-serial unit, one bit a
// cycle: a frame byte that enters the CRC holds off the next request until the
// unit is done, the two CRC bytes and the local write cause no hold, and the
// last frame byte is followed by the frame check. Each byte of a reply that
// enters the CRC waits for the unit, and any reply byte waits while the
// response side stalls. No request is taken while a reply is being built;
// the last reply byte waits in the output register while the next request
// is already accepted.
module modbus_rtu_read_holding_slave_unit
   import mrhs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [7:0]        req_rx_byte,
   input  logic [3:0]        req_reg_index,
   input  logic [15:0]       req_reg_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last_byte,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE, S_RX_CRC, S_CHECK, S_SEND, S_SEND_CRC, S_CRC_LO, S_CRC_HI
   } state_type;

   typedef enum logic [2:0] {
      ST_ADDR, ST_CODE, ST_COUNT, ST_HI, ST_LO
   } step_type;

   state_type        state_ff, state_in;
   step_type         step_ff, step_in;
   logic [2:0]       pos_ff, pos_in;
   logic [7:0]       code_ff, code_in;
   logic [15:0]      start_ff, start_in;
   logic [15:0]      count_ff, count_in;
   logic [15:0]      rx_crc_ff, rx_crc_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] remaining_ff, remaining_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       tx_byte_ff, tx_byte_in;
   logic             last_ff, last_in;
   logic [7:0]       slave_addr_ff;

   crc_ctl_type      crc_ctl;
   logic [7:0]       crc_byte;
   logic             crc_busy;
   logic [15:0]      crc_val;

   logic             tbl_wr_en;
   logic [15:0]      tbl_rd_data;

   logic             req_fire;
   logic             out_free;
   logic             csr_wr;
   logic             frame_ok;
   logic [IDX_W-1:0] first_idx;
   logic [16:0]      span_end;
   logic [CNT_W-1:0] size;

   assign req_fire = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign frame_ok = (rx_crc_ff == crc_val) && (code_ff == FUNC_READ_HOLDING)
                  && (start_ff >= 16'd1) && (start_ff <= 16'(REG_COUNT));
   assign first_idx = IDX_W'(start_ff - 16'd1);
   assign span_end  = 17'(first_idx) + 17'(count_ff);
   // clip the count to the table end
   assign size = (span_end > 17'(REG_COUNT)) ? (CNT_W'(REG_COUNT) - CNT_W'(first_idx))
                                               : CNT_W'(count_ff);

   assign tbl_wr_en = req_fire && (req_op == OP_REG_WRITE)
                   && (32'(req_reg_index) < 32'(REG_COUNT));

   mrhs_crc_serial u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (crc_ctl),
      .data_byte (crc_byte),
      .busy      (crc_busy),
      .crc       (crc_val)
   );

   mrhs_reg_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_idx  (IDX_W'(req_reg_index)),
      .wr_data (req_reg_value),
      .rd_idx  (rd_idx_ff),
      .rd_data (tbl_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      code_in      = code_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      rx_crc_in    = rx_crc_ff;
      rd_idx_in    = rd_idx_ff;
      remaining_in = remaining_ff;
      tx_byte_in   = tx_byte_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      crc_ctl      = '0;
      crc_byte     = req_rx_byte;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_op == OP_LINE_BYTE)
                && !((pos_ff == 3'd0) && (req_rx_byte != slave_addr_ff))) begin
               case (pos_ff)
                  3'd1:    code_in   = req_rx_byte;
                  3'd2:    start_in  = {req_rx_byte, start_ff[7:0]};
                  3'd3:    start_in  = {start_ff[15:8], req_rx_byte};
                  3'd4:    count_in  = {req_rx_byte, count_ff[7:0]};
                  3'd5:    count_in  = {count_ff[15:8], req_rx_byte};
                  3'd6:    rx_crc_in = {rx_crc_ff[15:8], req_rx_byte};
                  3'd7:    rx_crc_in = {req_rx_byte, rx_crc_ff[7:0]};
                  default: ;
               endcase
               pos_in = pos_ff + 3'd1;
               if (pos_ff < 3'd6) begin
                  crc_ctl.start = 1'b1;
                  state_in      = S_RX_CRC;
               end else if (pos_ff == 3'd7) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_RX_CRC: begin
            if (!crc_busy) begin
               state_in = S_IDLE;
            end
         end
         S_CHECK: begin
            crc_ctl.init = 1'b1;
            if (frame_ok) begin
               rd_idx_in    = first_idx;
               remaining_in = size;
               step_in      = ST_ADDR;
               state_in     = S_SEND;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SEND: begin
            if (out_free) begin
               case (step_ff)
                  ST_ADDR:  crc_byte = slave_addr_ff;
                  ST_CODE:  crc_byte = FUNC_READ_HOLDING;
                  ST_COUNT: crc_byte = 8'({remaining_ff, 1'b0});
                  ST_HI:    crc_byte = tbl_rd_data[15:8];
                  default:  crc_byte = tbl_rd_data[7:0];
               endcase
               tx_byte_in    = crc_byte;
               last_in       = 1'b0;
               rsp_valid_in  = 1'b1;
               crc_ctl.start = 1'b1;
               state_in      = S_SEND_CRC;
            end
         end
         S_SEND_CRC: begin
            if (!crc_busy) begin
               state_in = S_SEND;
               case (step_ff)
                  ST_ADDR: step_in = ST_CODE;
                  ST_CODE: step_in = ST_COUNT;
                  ST_COUNT: begin
                     step_in = ST_HI;
                     if (remaining_ff == '0) begin
                        state_in = S_CRC_LO;
                     end
                  end
                  ST_HI: step_in = ST_LO;
                  default: begin
                     step_in      = ST_HI;
                     rd_idx_in    = rd_idx_ff + IDX_W'(1);
                     remaining_in = remaining_ff - CNT_W'(1);
                     if (remaining_ff == CNT_W'(1)) begin
                        state_in = S_CRC_LO;
                     end
                  end
               endcase
            end
         end
         S_CRC_LO: begin
            if (out_free) begin
               tx_byte_in   = crc_val[7:0];
               last_in      = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = S_CRC_HI;
            end
         end
         S_CRC_HI: begin
            if (out_free) begin
               tx_byte_in   = crc_val[15:8];
               last_in      = 1'b1;
               rsp_valid_in = 1'b1;
               crc_ctl.init = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff      <= step_in;
      code_ff      <= code_in;
      start_ff     <= start_in;
      count_ff     <= count_in;
      rx_crc_ff    <= rx_crc_in;
      rd_idx_ff    <= rd_idx_in;
      remaining_ff <= remaining_in;
      tx_byte_ff   <= tx_byte_in;
      last_ff      <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= SLAVE_ADDR_RESET;
      end else if (csr_wr && (csr_paddr[2] == CSR_IDX_SLAVE_ADDR)) begin
         slave_addr_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_SLAVE_ADDR) ? {24'h000000, slave_addr_ff}
                                                            : 32'h00000000;
   assign csr_pready = 1'b1;

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = tx_byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

@@ hdl/mrhs_checker.sv @@
module mrhs_checker
   import mrhs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last_byte
);

   // a stalled response byte holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last_byte))
      else $error("stalled response byte changed");

   // no request is taken while a reply frame is still in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_byte |-> req_stall)
      else $error("request accepted in the middle of a reply");

   // once the final byte of a reply is taken, the next byte opens a new frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_byte |=> !(rsp_valid && rsp_last_byte))
      else $error("final reply byte followed by another final byte");

   // a reply byte never appears while requests are being taken freely
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && !req_stall |=> !rsp_valid)
      else $error("reply started on the cycle after a request");

endmodule

bind modbus_rtu_read_holding_slave_unit mrhs_checker u_mrhs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_tx_byte   (rsp_tx_byte),
   .rsp_last_byte (rsp_last_byte)
);

@@ verif/modbus_rtu_read_holding_slave_unit_test.sv @@
module modbus_rtu_read_holding_slave_unit_test;
   import mrhs_pkg::*;

   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 40;
   localparam int SPARE_REG_IDX   = 1;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } reply_byte_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op = OP_LINE_BYTE;
   logic [7:0]        req_rx_byte = 8'h00;
   logic [3:0]        req_reg_index = 4'h0;
   logic [15:0]       req_reg_value = 16'h0000;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_tx_byte;
   logic              rsp_last_byte;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // slave state as the predictor sees it
   logic [15:0] holding_regs [REG_COUNT];
   logic [7:0]  frame_buf [8];
   logic [3:0]  frame_pos;
   logic [15:0] frame_crc;
   logic [7:0]  station_addr;

   reply_byte_type reply_due[$];
   int          error_count = 0;
   int          requests_sent = 0;
   int          send_idle_pct = 32;
   int          recv_idle_pct = 65;
   logic        hold_off_go = 1'b0;
   int          hold_off_len = 0;
   int          quiet_cycles = 0;

   modbus_rtu_read_holding_slave_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_rx_byte   (req_rx_byte),
      .req_reg_index (req_reg_index),
      .req_reg_value (req_reg_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      int          k;
      c = crc ^ {8'h00, b};
      for (k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void reset_slave_model();
      int i;
      for (i = 0; i < REG_COUNT; i++) begin
         holding_regs[i] = (i == 0) ? RESET_REG0 : ((i == 1) ? RESET_REG1 : 16'h0000);
      end
      for (i = 0; i < 8; i++) begin
         frame_buf[i] = 8'h00;
      end
      frame_pos    = 4'd0;
      frame_crc    = CRC_INIT;
      station_addr = SLAVE_ADDR_RESET;
   endfunction

   function automatic void build_reply();
      logic [7:0]  body[$];
      logic [15:0] crc;
      logic [31:0] start_addr;
      logic [31:0] word_count;
      int          first_idx;
      int          span;
      int          i;
      if (frame_buf[1] != FUNC_READ_HOLDING) begin
         return;
      end
      start_addr = {16'h0000, frame_buf[2], frame_buf[3]};
      word_count = {16'h0000, frame_buf[4], frame_buf[5]};
      if (start_addr < 1 || start_addr > REG_COUNT) begin
         return;
      end
      first_idx = int'(start_addr) - 1;
      // clip at the table end
      span = (first_idx + word_count > REG_COUNT) ? REG_COUNT - first_idx : int'(word_count);
      body.push_back(station_addr);
      body.push_back(FUNC_READ_HOLDING);
      body.push_back(8'(span * 2));
      for (i = 0; i < span; i++) begin
         body.push_back(holding_regs[first_idx + i][15:8]);
         body.push_back(holding_regs[first_idx + i][7:0]);
      end
      crc = CRC_INIT;
      for (i = 0; i < body.size(); i++) begin
         crc = crc16_step(crc, body[i]);
         reply_due.push_back('{tx_byte: body[i], last_byte: 1'b0});
      end
      reply_due.push_back('{tx_byte: crc[7:0], last_byte: 1'b0});
      reply_due.push_back('{tx_byte: crc[15:8], last_byte: 1'b1});
   endfunction

   function automatic void take_request(logic op, logic [7:0] rx, logic [3:0] idx,
                                        logic [15:0] val);
      logic crc_ok;
      if (op == OP_REG_WRITE) begin
         if (idx < REG_COUNT) begin
            holding_regs[idx] = val;
         end
         return;
      end
      if (frame_pos == 0 && rx != station_addr) begin
         return;
      end
      frame_buf[frame_pos[2:0]] = rx;
      if (frame_pos < 6) begin
         frame_crc = crc16_step(frame_crc, rx);
      end
      frame_pos = frame_pos + 4'd1;
      if (frame_pos < 8) begin
         return;
      end
      crc_ok    = ({frame_buf[7], frame_buf[6]} == frame_crc);
      frame_pos = 4'd0;
      frame_crc = CRC_INIT;
      if (crc_ok) begin
         build_reply();
      end
   endfunction

   function automatic void check_reply_byte(logic [7:0] tx, logic is_last);
      reply_byte_type due;
      if (reply_due.size() == 0) begin
         $error("reply byte %02h with no reply outstanding", tx);
         error_count++;
         return;
      end
      due = reply_due.pop_front();
      if (tx !== due.tx_byte) begin
         $error("tx_byte: expected %02h, actual %02h", due.tx_byte, tx);
         error_count++;
      end
      if (is_last !== due.last_byte) begin
         $error("last_byte: expected %0b, actual %0b", due.last_byte, is_last);
         error_count++;
      end
   endfunction

   // check replies first so that a new request never overtakes them
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_reply_byte(rsp_tx_byte, rsp_last_byte);
         end
         if (req_valid && !req_stall) begin
            take_request(req_op, req_rx_byte, req_reg_index, req_reg_value);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_off_go && (hold_off_len < HOLD_OFF_CYCLES)) begin
         rsp_stall    <= 1'b1;
         hold_off_len <= hold_off_len + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(logic op, logic [7:0] rx, logic [3:0] idx, logic [15:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_rx_byte   <= rx;
      req_reg_index <= idx;
      req_reg_value <= val;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   task automatic send_line_byte(logic [7:0] rx);
      send_request(OP_LINE_BYTE, rx, 4'($urandom), 16'($urandom));
   endtask

   task automatic send_reg_write(logic [3:0] idx, logic [15:0] val);
      send_request(OP_REG_WRITE, 8'($urandom), idx, val);
   endtask

   function automatic logic [63:0] build_frame(logic [7:0] addr, logic [7:0] func,
                                               logic [15:0] start_addr,
                                               logic [15:0] word_count, logic spoil_crc);
      logic [63:0] f;
      logic [15:0] crc;
      int          i;
      f[7:0]   = addr;
      f[15:8]  = func;
      f[23:16] = start_addr[15:8];
      f[31:24] = start_addr[7:0];
      f[39:32] = word_count[15:8];
      f[47:40] = word_count[7:0];
      crc = CRC_INIT;
      for (i = 0; i < 6; i++) begin
         crc = crc16_step(crc, f[8*i +: 8]);
      end
      if (spoil_crc) begin
         crc = crc ^ (16'h0001 << $urandom_range(15));
      end
      f[55:48] = crc[7:0];
      f[63:56] = crc[15:8];
      return f;
   endfunction

   // write_pct: chance of a local register write slipped in before each byte
   task automatic send_frame(logic [63:0] f, int write_pct);
      int i;
      for (i = 0; i < 8; i++) begin
         if ($urandom_range(99) < write_pct) begin
            send_reg_write(4'($urandom), 16'($urandom));
         end
         send_line_byte(f[8*i +: 8]);
      end
   endtask

   task automatic send_random_frame();
      int          kind;
      int          i;
      logic [7:0]  addr;
      logic [7:0]  func;
      logic [15:0] start_addr;
      logic [15:0] word_count;
      logic        spoil;
      kind       = $urandom_range(99);
      addr       = station_addr;
      func       = FUNC_READ_HOLDING;
      start_addr = 16'($urandom_range(1, REG_COUNT));
      word_count = ($urandom_range(9) < 8) ? 16'($urandom_range(0, 20)) : 16'($urandom);
      spoil      = 1'b0;
      if (kind >= 87) begin
         // line noise
         for (i = $urandom_range(1, 3); i > 0; i--) begin
            send_line_byte(8'($urandom));
         end
         return;
      end
      if (kind >= 79) begin
         do addr = 8'($urandom); while (addr == station_addr);
      end else if (kind >= 71) begin
         do func = 8'($urandom); while (func == FUNC_READ_HOLDING);
      end else if (kind >= 63) begin
         spoil = 1'b1;
      end else if (kind >= 55) begin
         start_addr = $urandom_range(1) ? 16'h0000 : 16'($urandom_range(REG_COUNT + 1, 65535));
      end
      send_frame(build_frame(addr, func, start_addr, word_count, spoil), 8);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reply_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(int reg_idx, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * reg_idx);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (reg_idx == CSR_IDX_SLAVE_ADDR) begin
         station_addr = data[7:0];
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      logic [63:0] f;
      int          i;
      send_line_byte(8'hFF);
      send_reg_write(4'hF, 16'hFFFF);
      send_reg_write(4'h0, 16'h0000);
      // whole table, with a local write in the middle of the frame
      f = build_frame(station_addr, FUNC_READ_HOLDING, 16'd1, 16'hFFFF, 1'b0);
      for (i = 0; i < 8; i++) begin
         if (i == 4) begin
            send_reg_write(4'h2, 16'hA5A5);
         end
         send_line_byte(f[8*i +: 8]);
      end
      // last register, zero count
      send_frame(build_frame(station_addr, FUNC_READ_HOLDING, 16'(REG_COUNT), 16'd0, 1'b0), 0);
   endtask

   task automatic test_station_addresses();
      logic [7:0] addr_list [5];
      int         n;
      addr_list[0] = 8'h00;
      addr_list[1] = 8'hFF;
      addr_list[2] = 8'd247;
      addr_list[3] = 8'($urandom_range(2, 246));
      addr_list[4] = SLAVE_ADDR_RESET;
      for (n = 0; n < 5; n++) begin
         wait_idle();
         write_csr(CSR_IDX_SLAVE_ADDR, {24'($urandom), addr_list[n]});
         if (n == 2) begin
            write_csr(SPARE_REG_IDX, $urandom);
         end
         send_frame(build_frame(station_addr, FUNC_READ_HOLDING,
                                16'($urandom_range(1, REG_COUNT)),
                                16'($urandom_range(0, 20)), 1'b0), 10);
      end
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int n_requests);
      int first_count;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first_count   = requests_sent;
      while (requests_sent - first_count < n_requests) begin
         send_random_frame();
      end
   endtask

   // hold the reply side off while good frames keep coming
   task automatic test_back_pressure();
      int n;
      send_idle_pct = 0;
      hold_off_go <= 1'b1;
      for (n = 0; n < 3; n++) begin
         send_frame(build_frame(station_addr, FUNC_READ_HOLDING,
                                16'($urandom_range(1, REG_COUNT)),
                                16'($urandom_range(0, 20)), 1'b0), 0);
      end
   endtask

   initial begin
      reset_slave_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_station_addresses();
      test_random_traffic(32, 65, 8);
      test_random_traffic(65, 32, 8);
      test_back_pressure();
      test_random_traffic(0, 0, 8);
      wait_idle();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
